// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

// ===== rtl/sha_pkg.sv =====
// Types, constants and round functions of the SHA-256/224 core
package sha_pkg;
	typedef logic [31:0] word_t;

	localparam int unsigned NumRounds = 64;
	localparam logic MODE_SHA256 = 1'b0;
	localparam logic MODE_SHA224 = 1'b1;

	typedef struct packed {
		logic       load_iv;
		logic       mode;
		logic       wr_word;
		logic [3:0] wr_idx;
		word_t      wr_data;
		logic       start;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k [64] = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
		return k[i];
	endfunction

	function automatic word_t init_value(input logic mode, input logic [2:0] i);
		word_t iv256 [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
			32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
		word_t iv224 [8] = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
			32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};
		return (mode == MODE_SHA224) ? iv224[i] : iv256[i];
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== rtl/sha_stream_if.sv =====
// Valid/ready channel interfaces for message and digest requests
interface sha_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [2:0]  bytes_valid;
	logic        end_of_message;
	modport source (output valid, message_word, bytes_valid, end_of_message, input ready);
	modport sink (input valid, message_word, bytes_valid, end_of_message, output ready);
endinterface

interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_sha224_hash_core.sv =====
// SHA-256/224 hash core top level
//  channel | dir | handshake   | payload
//  msg     | in  | valid/ready | message_word, bytes_valid, end_of_message
//  dig     | out | valid/ready | digest_word, word_index, last_word
//  cfg     | in  | cfg_we      | cfg_wdata (digest_mode)
// Words are accepted while idle and cfg_we is low; the sixteenth word of a block
// holds the input off through launch, load, 64 rounds, fold into the hash state
// and return. The end-of-message request adds the padding words, one or two
// further block compressions, the digest words, which advance while dig.ready is
// high, and a restart step. Reset loads the SHA-256 initial value; the digest
// waits on dig.ready and input is held off until the last digest word has gone.
`include "assert_macros.svh"
module sha256_sha224_hash_core (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_wdata,
	sha_msg_if.sink   msg,
	sha_dig_if.source dig
);
	import sha_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [2:0] rd_idx;
	word_t rd_word;

	sha_ctrl u_ctrl (.clk, .arst_n, .cfg_we, .cfg_wdata, .msg, .dig, .cmd,
		.rd_idx, .rd_word, .sts);
	sha_datapath u_dp (.clk, .arst_n, .cmd, .rd_idx, .rd_word, .sts);

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, sts.busy, !msg.ready)
	`ASSERT_IMPL(a_no_out_busy, clk, arst_n, sts.busy, !dig.valid)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.start, sts.busy)
endmodule

// ===== rtl/sha_datapath.sv =====
// Block buffer, message schedule, round unit and hash state
module sha_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  sha_pkg::dp_cmd_t cmd,
	input  logic [2:0]      rd_idx,
	output sha_pkg::word_t  rd_word,
	output sha_pkg::dp_sts_t sts
);
	import sha_pkg::*;

	word_t w_q [16];
	word_t h_q [8];
	word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [6:0] rnd_q;
	logic busy_q;
	word_t s0, s1, w_new, t1, t2, wt;

	assign wt = w_q[0];
	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + round_k(rnd_q[5:0]) + wt;
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// block buffer doubles as the schedule shift line
	always_ff @(posedge clk) begin
		if (cmd.wr_word) begin
			w_q[cmd.wr_idx] <= cmd.wr_data;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_value(MODE_SHA256, 3'(i));
		end else if (cmd.load_iv) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_value(cmd.mode, 3'(i));
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			rnd_q <= '0;
		end else if (busy_q) begin
			if (rnd_q == 7'(NumRounds)) begin
				busy_q <= 1'b0;
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
				h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
			end else begin
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (busy_q && rnd_q != 7'(NumRounds)) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assign rd_word = h_q[rd_idx];
	assign sts.busy = busy_q;
endmodule

// ===== rtl/sha_ctrl.sv =====
// Controller: word intake, padding, length, compression launch, digest output
module sha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	sha_msg_if.sink         msg,
	sha_dig_if.source       dig,
	output sha_pkg::dp_cmd_t cmd,
	output logic [2:0]      rd_idx,
	input  sha_pkg::word_t  rd_word,
	input  sha_pkg::dp_sts_t sts
);
	import sha_pkg::*;

	typedef enum logic [2:0] {IDLE, COMP, WAIT, PAD, OUT, RESTART} state_t;
	state_t state_q, ret_q;
	logic mode_q;
	logic [3:0] pos_q;
	logic [63:0] len_q;
	logic [1:0] pad_q;   // 0 word 0x80.., 1 zeros, 2 high length, 3 low length
	logic [2:0] idx_q;
	logic [2:0] cnt;
	word_t keep, fword;
	logic fin;

	assign fin = msg.end_of_message;
	assign cnt = (msg.bytes_valid > 3'd4) ? 3'd4 : msg.bytes_valid;
	always_comb begin
		unique case (cnt)
			3'd0: keep = 32'h00000000;
			3'd1: keep = 32'hFF000000;
			3'd2: keep = 32'hFFFF0000;
			3'd3: keep = 32'hFFFFFF00;
			default: keep = 32'hFFFFFFFF;
		endcase
		fword = (msg.message_word & keep) | (cnt == 3'd4 ? 32'h0 : (32'h80000000 >> {cnt, 3'b000}));
	end

	assign msg.ready = (state_q == IDLE) && !cfg_we;
	assign dig.valid = (state_q == OUT);
	assign dig.digest_word = rd_word;
	assign dig.word_index = idx_q;
	assign dig.last_word = (idx_q == ((mode_q == MODE_SHA224) ? 3'd6 : 3'd7));
	assign rd_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		dp_cmd_t cmd_n;
		if (!arst_n) begin
			state_q <= IDLE; ret_q <= IDLE; mode_q <= MODE_SHA256;
			pos_q <= '0; len_q <= '0; pad_q <= '0; idx_q <= '0;
			cmd <= '0;
		end else begin
			cmd_n = '0;
			unique case (state_q)
				IDLE: begin
					if (cfg_we) begin
						mode_q <= cfg_wdata;
						cmd_n.load_iv = 1'b1; cmd_n.mode = cfg_wdata;
						pos_q <= '0; len_q <= '0;
					end else if (msg.valid) begin
						cmd_n.wr_word = 1'b1; cmd_n.wr_idx = pos_q;
						pos_q <= pos_q + 4'd1;
						if (!fin) begin
							len_q <= len_q + 64'd32;
							cmd_n.wr_data = msg.message_word;
							if (pos_q == 4'd15) begin
								state_q <= COMP; ret_q <= IDLE;
							end
						end else begin
							len_q <= len_q + 64'({cnt, 3'b000});
							cmd_n.wr_data = fword;
							// full final word still owes the marker word
							if (cnt == 3'd4) pad_q <= 2'd0;
							else pad_q <= (pos_q == 4'd13) ? 2'd2 : 2'd1;
							state_q <= (pos_q == 4'd15) ? COMP : PAD;
							ret_q <= PAD;
						end
					end
				end
				PAD: begin
					cmd_n.wr_word = 1'b1; cmd_n.wr_idx = pos_q;
					pos_q <= pos_q + 4'd1;
					unique case (pad_q)
						2'd0: begin
							cmd_n.wr_data = 32'h80000000;
							pad_q <= (pos_q == 4'd13) ? 2'd2 : 2'd1;
						end
						2'd1: begin
							cmd_n.wr_data = '0;
							if (pos_q == 4'd13) pad_q <= 2'd2;
						end
						2'd2: begin cmd_n.wr_data = len_q[63:32]; pad_q <= 2'd3; end
						default: cmd_n.wr_data = len_q[31:0];
					endcase
					if (pos_q == 4'd15 || pad_q == 2'd3) begin
						state_q <= COMP;
						ret_q <= (pad_q == 2'd3) ? OUT : PAD;
					end
				end
				COMP: begin
					cmd_n.start = 1'b1; state_q <= WAIT;
				end
				WAIT: begin
					if (!sts.busy && !cmd.start) begin
						state_q <= ret_q; idx_q <= '0;
					end
				end
				OUT: begin
					if (dig.ready) begin
						idx_q <= idx_q + 3'd1;
						if (dig.last_word) state_q <= RESTART;
					end
				end
				RESTART: begin
					cmd_n.load_iv = 1'b1; cmd_n.mode = mode_q;
					pos_q <= '0; len_q <= '0; idx_q <= '0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			cmd <= cmd_n;
		end
	end
endmodule
